// File: hdl/ptpr_pkg.sv
package ptpr_pkg;

   // Table sizes; slots index the tables by their low bits.
   localparam int MAX_FRAMES  = 16;
   localparam int MAX_SENSORS = 8;
   localparam int FIDX_W      = $clog2(MAX_FRAMES);
   localparam int SIDX_W      = $clog2(MAX_SENSORS);

   // Field widths of one beat.
   localparam int CMD_W    = 2;
   localparam int FRAME_W  = 4;
   localparam int SENSOR_W = 3;
   localparam int ROT_W    = 64;
   localparam int VEC_W    = 63;
   localparam int NRM_W    = 48;
   localparam int WGT_W    = 15;
   localparam int RES_W    = 32;
   localparam int SQ_W     = 48;

   // Fixed-point formats.
   localparam int UNIT_BITS = 14;
   localparam int ROT_BITS  = 2 * UNIT_BITS;
   localparam int POS_W     = 21;
   localparam int QC_W      = 16;
   localparam int QP_W      = 2 * QC_W;
   localparam int MAT_W     = QP_W + 2;
   localparam int PS_W      = MAT_W + POS_W;
   localparam int ACC_W     = 64;
   localparam int WIDE_W    = ACC_W - ROT_BITS + 1;
   localparam int SPLIT     = 18;
   localparam int PART_W    = MAT_W + WIDE_W - SPLIT;
   localparam int DIFF_W    = WIDE_W + 1;
   localparam int ND_W      = QC_W + DIFF_W;
   localparam int NSUM_W    = ND_W + 2;
   localparam int DOT_W     = NSUM_W - UNIT_BITS;
   localparam int PRODW_W   = DOT_W + WGT_W + 1;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_POSE   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SENSOR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_EVAL   = 2'd2;

   // Queue between front and back.
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   // Back pipeline depth.
   localparam int NSTG = 11;

   typedef struct packed {
      logic [ROT_W-1:0]    rot_s;
      logic [VEC_W-1:0]    tr_s;
      logic [ROT_W-1:0]    rot_p;
      logic [VEC_W-1:0]    tr_p;
      logic [VEC_W-1:0]    point;
      logic [VEC_W-1:0]    center;
      logic [NRM_W-1:0]    normal;
      logic [WGT_W-1:0]    weight;
      logic [FRAME_W-1:0]  frame;
      logic [SENSOR_W-1:0] sensor;
   } job_type;

   typedef logic [9:0][QP_W-1:0]  qprod_type;
   typedef logic [8:0][MAT_W-1:0] mat_type;

   // Signed 21-bit position component i of a packed vector.
   function automatic logic signed [POS_W-1:0] pos_at(input logic [VEC_W-1:0] w,
                                                      input int unsigned i);
      return $signed(w[i*POS_W +: POS_W]);
   endfunction

   // Signed 16-bit component i of a packed quaternion or normal.
   function automatic logic signed [QC_W-1:0] qc_at(input logic [ROT_W-1:0] w,
                                                    input int unsigned i);
      return $signed(w[i*QC_W +: QC_W]);
   endfunction

endpackage

// File: hdl/point_to_plane_residual_core.sv
// A factor beat accepted on the request side passes through the queue and then the
// back-end pipeline to rsp_valid; loads give no result.
// Throughput: one beat per cycle, loads and factors alike, while the queue is not full;
// the back end is fully pipelined and holds only while the result side stalls.
// Reset (synchronous, active high) empties the queue and the pipeline; the pose
// and sensor tables are not cleared and hold no meaning until loaded.
module point_to_plane_residual_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ptpr_pkg::CMD_W-1:0]      req_cmd,
   input  logic [ptpr_pkg::FRAME_W-1:0]    req_frame_slot,
   input  logic [ptpr_pkg::SENSOR_W-1:0]   req_sensor_slot,
   input  logic [ptpr_pkg::ROT_W-1:0]      req_rotation_wxyz,
   input  logic [ptpr_pkg::VEC_W-1:0]      req_translation_xyz,
   input  logic [ptpr_pkg::VEC_W-1:0]      req_point_xyz,
   input  logic [ptpr_pkg::VEC_W-1:0]      req_center_xyz,
   input  logic [ptpr_pkg::NRM_W-1:0]      req_normal_xyz,
   input  logic [ptpr_pkg::WGT_W-1:0]      req_factor_weight,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [ptpr_pkg::RES_W-1:0] rsp_residual,
   output logic [ptpr_pkg::SQ_W-1:0]       rsp_residual_squared,
   output logic [ptpr_pkg::FRAME_W-1:0]    rsp_frame_echo,
   output logic [ptpr_pkg::SENSOR_W-1:0]   rsp_sensor_echo
);
   import ptpr_pkg::*;

   // The front end takes every beat while the queue is not full. Load beats write
   // the pose or sensor table at once. A factor beat looks up both transforms in
   // the same cycle and enters the queue together with its point, plane and weight,
   // so later loads cannot disturb a factor already taken.
   logic    q_push, q_full, q_pop, q_valid;
   job_type q_in_job, q_out_job;

   ptpr_front u_front (
      .clock               (clock),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_frame_slot      (req_frame_slot),
      .req_sensor_slot     (req_sensor_slot),
      .req_rotation_wxyz   (req_rotation_wxyz),
      .req_translation_xyz (req_translation_xyz),
      .req_point_xyz       (req_point_xyz),
      .req_center_xyz      (req_center_xyz),
      .req_normal_xyz      (req_normal_xyz),
      .req_factor_weight   (req_factor_weight),
      .q_push              (q_push),
      .q_job               (q_in_job),
      .q_full              (q_full)
   );

   // A short queue decouples the two halves: the front keeps taking beats
   // while the result side stalls, until the queue fills.
   ptpr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (q_in_job),
      .full      (q_full),
      .pop       (q_pop),
      .out_valid (q_valid),
      .out_job   (q_out_job)
   );

   // The back end is an eleven-stage pipeline: quaternion products, rotation
   // matrices, the sensor transform, the pose transform in split partial
   // products, the normal dot product, weighting, saturation and the square.
   // Its last stage is the output register.
   ptpr_back u_back (
      .clock                (clock),
      .reset                (reset),
      .in_valid             (q_valid),
      .in_job               (q_out_job),
      .in_pop               (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_residual         (rsp_residual),
      .rsp_residual_squared (rsp_residual_squared),
      .rsp_frame_echo       (rsp_frame_echo),
      .rsp_sensor_echo      (rsp_sensor_echo)
   );

endmodule

// File: hdl/ptpr_front.sv
module ptpr_front (
   input  logic                            clock,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ptpr_pkg::CMD_W-1:0]      req_cmd,
   input  logic [ptpr_pkg::FRAME_W-1:0]    req_frame_slot,
   input  logic [ptpr_pkg::SENSOR_W-1:0]   req_sensor_slot,
   input  logic [ptpr_pkg::ROT_W-1:0]      req_rotation_wxyz,
   input  logic [ptpr_pkg::VEC_W-1:0]      req_translation_xyz,
   input  logic [ptpr_pkg::VEC_W-1:0]      req_point_xyz,
   input  logic [ptpr_pkg::VEC_W-1:0]      req_center_xyz,
   input  logic [ptpr_pkg::NRM_W-1:0]      req_normal_xyz,
   input  logic [ptpr_pkg::WGT_W-1:0]      req_factor_weight,
   output logic                            q_push,
   output ptpr_pkg::job_type               q_job,
   input  logic                            q_full
);
   import ptpr_pkg::*;

   logic [ROT_W-1:0] pose_rot_ff [MAX_FRAMES];
   logic [VEC_W-1:0] pose_tr_ff  [MAX_FRAMES];
   logic [ROT_W-1:0] sens_rot_ff [MAX_SENSORS];
   logic [VEC_W-1:0] sens_tr_ff  [MAX_SENSORS];

   logic              accept;
   logic [FIDX_W-1:0] fi;
   logic [SIDX_W-1:0] si;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign fi        = req_frame_slot[FIDX_W-1:0];
   assign si        = req_sensor_slot[SIDX_W-1:0];

   // Loads write the tables at the accepting edge, so a factor that follows
   // in the next beat already reads the new entry.
   always_ff @(posedge clock) begin
      if (accept && req_cmd == CMD_POSE) begin
         pose_rot_ff[fi] <= req_rotation_wxyz;
         pose_tr_ff[fi]  <= req_translation_xyz;
      end
      if (accept && req_cmd == CMD_SENSOR) begin
         sens_rot_ff[si] <= req_rotation_wxyz;
         sens_tr_ff[si]  <= req_translation_xyz;
      end
   end

   assign q_push = accept && req_cmd == CMD_EVAL;

   always_comb begin
      q_job.rot_s  = sens_rot_ff[si];
      q_job.tr_s   = sens_tr_ff[si];
      q_job.rot_p  = pose_rot_ff[fi];
      q_job.tr_p   = pose_tr_ff[fi];
      q_job.point  = req_point_xyz;
      q_job.center = req_center_xyz;
      q_job.normal = req_normal_xyz;
      q_job.weight = req_factor_weight;
      q_job.frame  = req_frame_slot;
      q_job.sensor = req_sensor_slot;
   end

endmodule

// File: hdl/ptpr_queue.sv
module ptpr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ptpr_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              out_valid,
   output ptpr_pkg::job_type out_job
);
   import ptpr_pkg::*;

   job_type           mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;

   assign full      = cnt_ff == (QPTR_W+1)'(QDEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_job   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> out_valid)
      else $error("queue read while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QPTR_W+1)'(QDEPTH))
      else $error("queue count beyond depth");

endmodule

// File: hdl/ptpr_back.sv
module ptpr_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  ptpr_pkg::job_type               in_job,
   output logic                            in_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [ptpr_pkg::RES_W-1:0] rsp_residual,
   output logic [ptpr_pkg::SQ_W-1:0]       rsp_residual_squared,
   output logic [ptpr_pkg::FRAME_W-1:0]    rsp_frame_echo,
   output logic [ptpr_pkg::SENSOR_W-1:0]   rsp_sensor_echo
);
   import ptpr_pkg::*;

   localparam logic signed [ACC_W-1:0]   RND_ROT  = ACC_W'(64'sd1 <<< (ROT_BITS - 1));
   localparam logic signed [NSUM_W-1:0]  RND_N    = NSUM_W'(64'sd1 <<< (UNIT_BITS - 1));
   localparam logic signed [PRODW_W-1:0] RND_W    = PRODW_W'(64'sd1 <<< (UNIT_BITS - 1));
   localparam logic signed [PRODW_W-1:0] RES_MAXV = PRODW_W'(64'sd2147483647);
   localparam logic signed [PRODW_W-1:0] RES_MINV = PRODW_W'(-64'sd2147483648);
   localparam logic [ACC_W-1:0]          SQ_MAXV  = ACC_W'((65'd1 << SQ_W) - 65'd1);

   function automatic qprod_type quat_prod(input logic [ROT_W-1:0] rot);
      logic signed [QP_W-1:0] w, x, y, z;
      qprod_type r;
      w = qc_at(rot, 0);
      x = qc_at(rot, 1);
      y = qc_at(rot, 2);
      z = qc_at(rot, 3);
      r[0] = w * w;
      r[1] = x * x;
      r[2] = y * y;
      r[3] = z * z;
      r[4] = x * y;
      r[5] = w * z;
      r[6] = x * z;
      r[7] = w * y;
      r[8] = y * z;
      r[9] = w * x;
      return r;
   endfunction

   function automatic mat_type mat_build(input qprod_type q);
      logic signed [MAT_W-1:0] a [10];
      mat_type m;
      for (int i = 0; i < 10; i++) begin
         a[i] = $signed(q[i]);
      end
      m[0] = a[0] + a[1] - a[2] - a[3];
      m[1] = (a[4] - a[5]) <<< 1;
      m[2] = (a[6] + a[7]) <<< 1;
      m[3] = (a[4] + a[5]) <<< 1;
      m[4] = a[0] - a[1] + a[2] - a[3];
      m[5] = (a[8] - a[9]) <<< 1;
      m[6] = (a[6] - a[7]) <<< 1;
      m[7] = (a[8] + a[9]) <<< 1;
      m[8] = a[0] - a[1] - a[2] + a[3];
      return m;
   endfunction

   logic              adv;
   logic [NSTG-1:0]   vld_ff;
   job_type           job_ff [NSTG];

   qprod_type                  qs_ff, qp_ff;
   mat_type                    ms_ff, mp1_ff, mp2_ff, mp3_ff;
   logic signed [PS_W-1:0]     ps_in [9], ps_ff [9];
   logic signed [WIDE_W-1:0]   ref_in [3], ref_ff [3];
   logic signed [PART_W-1:0]   pl_in [9], pl_ff [9], ph_in [9], ph_ff [9];
   logic signed [WIDE_W-1:0]   world_in [3], world_ff [3];
   logic signed [ND_W-1:0]     nd_in [3], nd_ff [3];
   logic signed [DOT_W-1:0]    dot_in, dot_ff;
   logic signed [PRODW_W-1:0]  prod_in, prod_ff;
   logic signed [RES_W-1:0]    r_in, r_ff, res_ff;
   logic [SQ_W-1:0]            sq_in, sq_ff;

   // The whole pipe moves together; it holds only while the result waits.
   assign adv    = !(vld_ff[NSTG-1] && rsp_stall);
   assign in_pop = in_valid && adv;

   // Sensor rotation of the point.
   always_comb begin
      logic signed [PS_W-1:0] a, b;
      for (int k = 0; k < 9; k++) begin
         a = $signed(ms_ff[k]);
         b = pos_at(job_ff[1].point, k % 3);
         ps_in[k] = a * b;
      end
   end

   always_comb begin
      logic signed [ACC_W-1:0] acc;
      for (int i = 0; i < 3; i++) begin
         acc = ps_ff[3*i] + ps_ff[3*i+1] + ps_ff[3*i+2];
         acc = (acc + RND_ROT) >>> ROT_BITS;
         ref_in[i] = WIDE_W'(acc + pos_at(job_ff[2].tr_s, i));
      end
   end

   // Pose rotation, in two partial products per term.
   always_comb begin
      logic signed [PART_W-1:0] m, lo, hi;
      for (int k = 0; k < 9; k++) begin
         m  = $signed(mp3_ff[k]);
         lo = $signed({1'b0, ref_ff[k % 3][SPLIT-1:0]});
         hi = $signed(ref_ff[k % 3][WIDE_W-1:SPLIT]);
         pl_in[k] = m * lo;
         ph_in[k] = m * hi;
      end
   end

   always_comb begin
      logic signed [ACC_W-1:0] acc, e;
      for (int i = 0; i < 3; i++) begin
         acc = '0;
         for (int j = 0; j < 3; j++) begin
            e   = ph_ff[3*i+j];
            e   = e <<< SPLIT;
            acc = acc + e + pl_ff[3*i+j];
         end
         acc = (acc + RND_ROT) >>> ROT_BITS;
         world_in[i] = WIDE_W'(acc + pos_at(job_ff[4].tr_p, i));
      end
   end

   always_comb begin
      logic signed [ND_W-1:0] d, n;
      for (int i = 0; i < 3; i++) begin
         d = world_ff[i];
         d = d - pos_at(job_ff[5].center, i);
         n = qc_at(ROT_W'(job_ff[5].normal), i);
         nd_in[i] = n * d;
      end
   end

   always_comb begin
      logic signed [NSUM_W-1:0] s;
      s = nd_ff[0];
      s = s + nd_ff[1] + nd_ff[2] + RND_N;
      dot_in = DOT_W'(s >>> UNIT_BITS);
   end

   always_comb begin
      logic signed [PRODW_W-1:0] a, b;
      a = dot_ff;
      b = $signed({1'b0, job_ff[7].weight});
      prod_in = a * b;
   end

   always_comb begin
      logic signed [PRODW_W-1:0] t;
      t = (prod_ff + RND_W) >>> UNIT_BITS;
      if (t > RES_MAXV) begin
         r_in = RES_W'(RES_MAXV);
      end else if (t < RES_MINV) begin
         r_in = RES_W'(RES_MINV);
      end else begin
         r_in = RES_W'(t);
      end
   end

   always_comb begin
      logic signed [ACC_W-1:0] a;
      logic [ACC_W-1:0]        sq;
      a  = r_ff;
      sq = a * a;
      sq_in = (sq > SQ_MAXV) ? SQ_MAXV[SQ_W-1:0] : sq[SQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTG-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         job_ff[0] <= in_job;
         for (int k = 1; k < NSTG; k++) begin
            job_ff[k] <= job_ff[k-1];
         end
         qs_ff    <= quat_prod(in_job.rot_s);
         qp_ff    <= quat_prod(in_job.rot_p);
         ms_ff    <= mat_build(qs_ff);
         mp1_ff   <= mat_build(qp_ff);
         mp2_ff   <= mp1_ff;
         mp3_ff   <= mp2_ff;
         ps_ff    <= ps_in;
         ref_ff   <= ref_in;
         pl_ff    <= pl_in;
         ph_ff    <= ph_in;
         world_ff <= world_in;
         nd_ff    <= nd_in;
         dot_ff   <= dot_in;
         prod_ff  <= prod_in;
         r_ff     <= r_in;
         res_ff   <= r_ff;
         sq_ff    <= sq_in;
      end
   end

   assign rsp_valid            = vld_ff[NSTG-1];
   assign rsp_residual         = res_ff;
   assign rsp_residual_squared = sq_ff;
   assign rsp_frame_echo       = job_ff[NSTG-1].frame;
   assign rsp_sensor_echo      = job_ff[NSTG-1].sensor;

   a_hold: assert property (@(posedge clock) disable iff (reset) !adv |=> $stable(vld_ff))
      else $error("pipeline moved while held");
   a_zero_sq: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_residual == '0) |-> rsp_residual_squared == '0)
      else $error("square of zero residual not zero");
   a_sq_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_residual > 32'sd16777216 || rsp_residual < -32'sd16777216))
      |-> rsp_residual_squared == SQ_MAXV[SQ_W-1:0])
      else $error("large residual square not saturated");

endmodule

// File: tb/sv/tb.sv
module tb;
   import ptpr_pkg::*;

   // Clock and a single synchronous reset pulse at the start of the run.
   logic clock;
   logic reset;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Request channel, driven by the sender process.
   logic                 req_valid;
   logic                 req_stall;
   logic [CMD_W-1:0]     req_cmd;
   logic [FRAME_W-1:0]   req_frame_slot;
   logic [SENSOR_W-1:0]  req_sensor_slot;
   logic [ROT_W-1:0]     req_rotation_wxyz;
   logic [VEC_W-1:0]     req_translation_xyz;
   logic [VEC_W-1:0]     req_point_xyz;
   logic [VEC_W-1:0]     req_center_xyz;
   logic [NRM_W-1:0]     req_normal_xyz;
   logic [WGT_W-1:0]     req_factor_weight;

   // Response channel; rsp_stall is driven by the receiver process.
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic signed [RES_W-1:0] rsp_residual;
   logic [SQ_W-1:0]      rsp_residual_squared;
   logic [FRAME_W-1:0]   rsp_frame_echo;
   logic [SENSOR_W-1:0]  rsp_sensor_echo;

   point_to_plane_residual_core u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_cmd              (req_cmd),
      .req_frame_slot       (req_frame_slot),
      .req_sensor_slot      (req_sensor_slot),
      .req_rotation_wxyz    (req_rotation_wxyz),
      .req_translation_xyz  (req_translation_xyz),
      .req_point_xyz        (req_point_xyz),
      .req_center_xyz       (req_center_xyz),
      .req_normal_xyz       (req_normal_xyz),
      .req_factor_weight    (req_factor_weight),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_residual         (rsp_residual),
      .rsp_residual_squared (rsp_residual_squared),
      .rsp_frame_echo       (rsp_frame_echo),
      .rsp_sensor_echo      (rsp_sensor_echo)
   );

   // The command code that the block ignores.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // One input beat as the sender sees it.
   typedef struct {
      logic [CMD_W-1:0]    cmd;
      logic [FRAME_W-1:0]  frame;
      logic [SENSOR_W-1:0] sensor;
      logic [ROT_W-1:0]    rot;
      logic [VEC_W-1:0]    trans;
      logic [VEC_W-1:0]    point;
      logic [VEC_W-1:0]    center;
      logic [NRM_W-1:0]    normal;
      logic [WGT_W-1:0]    weight;
   } beat_type;

   // One residual beat as expected on the response side.
   typedef struct packed {
      logic signed [RES_W-1:0] res;
      logic [SQ_W-1:0]         sq;
      logic [FRAME_W-1:0]      frame;
      logic [SENSOR_W-1:0]     sensor;
   } residual_type;

   // Directed table row: the beat plus, where obvious, a hand-typed residual.
   typedef struct {
      beat_type     b;
      bit           typed;
      residual_type r;
   } row_type;

   // Private copy of the transform tables that mirrors what the block holds.
   logic [ROT_W-1:0] pose_rot_mirror   [MAX_FRAMES];
   logic [VEC_W-1:0] pose_tr_mirror    [MAX_FRAMES];
   logic [ROT_W-1:0] sensor_rot_mirror [MAX_SENSORS];
   logic [VEC_W-1:0] sensor_tr_mirror  [MAX_SENSORS];
   bit               pose_loaded       [MAX_FRAMES];
   bit               sensor_loaded     [MAX_SENSORS];

   residual_type pending_residuals[$];
   residual_type typed_residuals[$];
   bit           typed_flags[$];

   int  mismatch_count;
   int  residuals_seen;
   int  factors_sent;
   int  loads_sent;
   bit  sender_done;

   // Round half up: add half an LSB, then shift; >>> on a signed operand floors.
   function automatic longint signed round_half_up(input longint signed v, input int s);
      longint signed t;
      t = v + (longint'(1) <<< (s - 1));
      return t >>> s;
   endfunction

   function automatic longint signed comp21(input logic [VEC_W-1:0] w, input int i);
      logic signed [POS_W-1:0] f;
      f = w[i*POS_W +: POS_W];
      return longint'(f);
   endfunction

   function automatic longint signed comp16(input logic [ROT_W-1:0] w, input int i);
      logic signed [QC_W-1:0] f;
      f = w[i*QC_W +: QC_W];
      return longint'(f);
   endfunction

   // Rotate by a unit quaternion (matrix held at 28 fraction bits), then translate.
   task automatic rigid_move(input logic [ROT_W-1:0] q, input logic [VEC_W-1:0] tr,
                             input longint signed p[3], output longint signed o[3]);
      longint signed w, x, y, z;
      longint signed m[3][3];
      longint signed acc;
      w = comp16(q, 0); x = comp16(q, 1); y = comp16(q, 2); z = comp16(q, 3);
      m[0][0] = w*w + x*x - y*y - z*z;
      m[0][1] = 2*(x*y - w*z);
      m[0][2] = 2*(x*z + w*y);
      m[1][0] = 2*(x*y + w*z);
      m[1][1] = w*w - x*x + y*y - z*z;
      m[1][2] = 2*(y*z - w*x);
      m[2][0] = 2*(x*z - w*y);
      m[2][1] = 2*(y*z + w*x);
      m[2][2] = w*w - x*x - y*y + z*z;
      for (int i = 0; i < 3; i++) begin
         acc = m[i][0]*p[0] + m[i][1]*p[1] + m[i][2]*p[2];
         o[i] = round_half_up(acc, ROT_BITS) + comp21(tr, i);
      end
   endtask

   // Update the table mirror for loads; for a factor, compute its residual.
   task automatic predict_residual(input beat_type b, output bit produces,
                                   output residual_type r);
      longint signed p[3], mid[3], world[3];
      longint signed acc, dot, res;
      longint unsigned sq;
      int fi, si;
      fi = b.frame % MAX_FRAMES;
      si = b.sensor % MAX_SENSORS;
      produces = 1'b0;
      r = '{default: '0};
      case (b.cmd)
         CMD_POSE: begin
            pose_rot_mirror[fi] = b.rot;
            pose_tr_mirror[fi]  = b.trans;
            pose_loaded[fi]     = 1'b1;
         end
         CMD_SENSOR: begin
            sensor_rot_mirror[si] = b.rot;
            sensor_tr_mirror[si]  = b.trans;
            sensor_loaded[si]     = 1'b1;
         end
         CMD_EVAL: begin
            for (int i = 0; i < 3; i++) p[i] = comp21(b.point, i);
            rigid_move(sensor_rot_mirror[si], sensor_tr_mirror[si], p, mid);
            rigid_move(pose_rot_mirror[fi], pose_tr_mirror[fi], mid, world);
            acc = 0;
            for (int i = 0; i < 3; i++)
               acc += comp16(b.normal, i) * (world[i] - comp21(b.center, i));
            dot = round_half_up(acc, UNIT_BITS);
            res = round_half_up(dot * longint'(b.weight), UNIT_BITS);
            if (res > 64'sd2147483647) res = 64'sd2147483647;
            if (res < -64'sd2147483648) res = -64'sd2147483648;
            sq = longint'(res * res);
            if (sq > 64'hFFFF_FFFF_FFFF) sq = 64'hFFFF_FFFF_FFFF;
            r.res    = res[RES_W-1:0];
            r.sq     = sq[SQ_W-1:0];
            r.frame  = b.frame;
            r.sensor = b.sensor;
            produces = 1'b1;
         end
         default: ;  // the unused command code is dropped by the block
      endcase
   endtask

   // Random gap: mostly zero or short, occasionally long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [VEC_W-1:0] rand_vec(input int span);
      logic [VEC_W-1:0] v;
      logic signed [POS_W-1:0] c;
      for (int i = 0; i < 3; i++) begin
         c = POS_W'($signed($urandom_range(0, 2*span)) - span);
         v[i*POS_W +: POS_W] = c;
      end
      return v;
   endfunction

   function automatic logic [VEC_W-1:0] raw_vec();
      return VEC_W'({$urandom, $urandom});
   endfunction

   // Near-unit quaternion or normal: one large component plus small noise,
   // sometimes with fully random bits so every bit of the field toggles.
   function automatic logic [ROT_W-1:0] rand_unitish(input int comps);
      logic [ROT_W-1:0] v;
      int big;
      v = '0;
      if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
      big = $urandom_range(0, comps - 1);
      for (int i = 0; i < comps; i++) begin
         if (i == big)
            v[i*QC_W +: QC_W] = ($urandom_range(0, 1) ? 16'sd16384 : -16'sd16384)
                                + $signed(16'($urandom_range(0, 600))) - 16'sd300;
         else
            v[i*QC_W +: QC_W] = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
      end
      return v;
   endfunction

   function automatic beat_type load_beat(input logic [CMD_W-1:0] cmd, input int slot);
      beat_type b;
      b = '{default: '0};
      b.cmd    = cmd;
      b.frame  = FRAME_W'(slot);
      b.sensor = SENSOR_W'(slot);
      b.rot    = rand_unitish(4);
      b.trans  = ($urandom_range(0, 7) == 0) ? raw_vec() : rand_vec(200000);
      b.point  = raw_vec();
      b.center = raw_vec();
      b.normal = NRM_W'({$urandom, $urandom});
      b.weight = WGT_W'($urandom);
      return b;
   endfunction

   // A factor only ever names slots that have been loaded.
   function automatic beat_type factor_beat();
      beat_type b;
      int f, s;
      do f = $urandom_range(0, MAX_FRAMES - 1); while (!pose_loaded[f]);
      do s = $urandom_range(0, MAX_SENSORS - 1); while (!sensor_loaded[s]);
      b.cmd    = CMD_EVAL;
      b.frame  = FRAME_W'(f);
      b.sensor = SENSOR_W'(s);
      b.rot    = {$urandom, $urandom};
      b.trans  = raw_vec();
      b.point  = ($urandom_range(0, 5) == 0) ? raw_vec() : rand_vec(60000);
      b.center = ($urandom_range(0, 5) == 0) ? raw_vec() : rand_vec(60000);
      b.normal = NRM_W'(rand_unitish(3));
      case ($urandom_range(0, 5))
         0:       b.weight = 15'h7FFF;
         1:       b.weight = 15'd16384;
         2:       b.weight = 15'd0;
         default: b.weight = WGT_W'($urandom_range(0, 32767));
      endcase
      return b;
   endfunction

   // Drive one beat, holding it until the block takes it, then book its result.
   task automatic send_beat(input beat_type b, input bit typed, input residual_type r);
      bit           produces;
      residual_type guess;
      req_valid           <= 1'b1;
      req_cmd             <= b.cmd;
      req_frame_slot      <= b.frame;
      req_sensor_slot     <= b.sensor;
      req_rotation_wxyz   <= b.rot;
      req_translation_xyz <= b.trans;
      req_point_xyz       <= b.point;
      req_center_xyz      <= b.center;
      req_normal_xyz      <= b.normal;
      req_factor_weight   <= b.weight;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // Accepted at this edge; the predictor runs in beat order.
      predict_residual(b, produces, guess);
      if (produces) begin
         pending_residuals = {pending_residuals, guess};
         typed_residuals   = {typed_residuals, r};
         typed_flags       = {typed_flags, typed};
         factors_sent++;
      end else if (b.cmd == CMD_POSE || b.cmd == CMD_SENSOR) begin
         loads_sent++;
      end
   endtask

   task automatic idle_sender(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Directed rows: identity transforms give obvious numbers, plus extremes.
   localparam logic [ROT_W-1:0] Q_IDENT = 64'h0000_0000_0000_4000;
   localparam logic [ROT_W-1:0] Q_NEG   = 64'h0000_0000_0000_C000;
   localparam logic [NRM_W-1:0] N_X     = 48'h0000_0000_4000;
   localparam logic [NRM_W-1:0] N_NEGZ  = 48'hC000_0000_0000;
   localparam logic [VEC_W-1:0] V_MAX   = {21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF};
   localparam logic [VEC_W-1:0] V_MIN   = {21'h100000, 21'h100000, 21'h100000};

   function automatic row_type mk(input logic [CMD_W-1:0] cmd, input int f, input int s,
                                  input logic [ROT_W-1:0] q, input logic [VEC_W-1:0] t,
                                  input logic [VEC_W-1:0] p, input logic [VEC_W-1:0] c,
                                  input logic [NRM_W-1:0] n, input logic [WGT_W-1:0] w,
                                  input bit typed, input longint signed res,
                                  input longint unsigned sq);
      row_type row;
      row.b     = '{cmd, FRAME_W'(f), SENSOR_W'(s), q, t, p, c, n, w};
      row.typed = typed;
      row.r     = '{res[RES_W-1:0], sq[SQ_W-1:0], FRAME_W'(f), SENSOR_W'(s)};
      return row;
   endfunction

   row_type directed_rows[$];

   initial begin
      directed_rows = '{
         // Identity pose in slot 0 and identity extrinsic in sensor 0.
         mk(CMD_POSE,   0, 0, Q_IDENT, '0, '0, '0, '0, 0, 0, 0, 0),
         mk(CMD_SENSOR, 0, 0, Q_IDENT, '0, '0, '0, '0, 0, 0, 0, 0),
         // Point x = 1.0 (1024), normal +x, weight one: residual 1024.
         mk(CMD_EVAL, 0, 0, '0, '0, 63'd1024, '0, N_X, 15'd16384, 1, 1024, 1048576),
         // Zero weight gives zero.
         mk(CMD_EVAL, 0, 0, '0, '0, 63'd1024, '0, N_X, 15'd0, 1, 0, 0),
         // Center equal to point gives zero.
         mk(CMD_EVAL, 0, 0, '0, '0, 63'd777, 63'd777, N_X, 15'd16384, 1, 0, 0),
         // Extreme positions with maximum weight, both signs.
         mk(CMD_EVAL, 0, 0, '0, '0, V_MAX, V_MIN, N_X, 15'h7FFF, 0, 0, 0),
         mk(CMD_EVAL, 0, 0, '0, '0, V_MIN, V_MAX, N_NEGZ, 15'h7FFF, 0, 0, 0),
         // Negated quaternion is the same rotation.
         mk(CMD_POSE,   15, 7, Q_NEG, V_MAX, '0, '0, '0, 0, 0, 0, 0),
         mk(CMD_SENSOR, 15, 7, Q_NEG, V_MIN, '0, '0, '0, 0, 0, 0, 0),
         mk(CMD_EVAL, 15, 7, '0, '0, V_MAX, V_MIN, 48'hFFFF_FFFF_FFFF, 15'h7FFF, 0, 0, 0),
         mk(CMD_EVAL, 15, 7, '0, '0, V_MIN, '0, N_NEGZ, 15'd16384, 0, 0, 0),
         // Full-scale quaternion components drive the matrix to its range edges.
         mk(CMD_POSE,   3, 0, 64'h7FFF_8000_7FFF_8000, V_MIN, '0, '0, '0, 0, 0, 0, 0),
         mk(CMD_SENSOR, 0, 3, 64'h8000_7FFF_8000_7FFF, V_MAX, '0, '0, '0, 0, 0, 0, 0),
         mk(CMD_EVAL, 3, 3, '0, '0, V_MAX, V_MIN, 48'h7FFF_7FFF_7FFF, 15'h7FFF, 0, 0, 0),
         mk(CMD_EVAL, 3, 3, '0, '0, V_MIN, V_MAX, 48'h8000_8000_8000, 15'h7FFF, 0, 0, 0),
         // The unused command code must be dropped without a result.
         mk(CMD_UNUSED, 0, 0, '1, '1, '1, '1, '1, '1, 0, 0, 0),
         // Factor after the dropped beat still sees the identity tables.
         mk(CMD_EVAL, 0, 0, '0, '0, 63'd2048, 63'd1024, N_X, 15'd8192, 1, 512, 262144)
      };
   end

   // Sender: reset, directed table, random stream.
   initial begin
      beat_type b;
      int       roll;
      int       target_items;
      int       sent;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_cmd             = '0;
      req_frame_slot      = '0;
      req_sensor_slot     = '0;
      req_rotation_wxyz   = '0;
      req_translation_xyz = '0;
      req_point_xyz       = '0;
      req_center_xyz      = '0;
      req_normal_xyz      = '0;
      req_factor_weight   = '0;
      mismatch_count      = 0;
      residuals_seen      = 0;
      factors_sent        = 0;
      loads_sent          = 0;
      sender_done         = 1'b0;
      for (int i = 0; i < MAX_FRAMES; i++) pose_loaded[i] = 1'b0;
      for (int i = 0; i < MAX_SENSORS; i++) sensor_loaded[i] = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_beat(directed_rows[i].b, directed_rows[i].typed, directed_rows[i].r);
         idle_sender(pick_gap());
      end

      // Random stream: mostly factors over loaded slots, with fresh loads mixed in
      // so table contents keep changing under traffic.
      target_items = 500;
      sent = 0;
      while (sent < target_items) begin
         roll = $urandom_range(0, 99);
         if (roll < 12)
            b = load_beat(CMD_POSE, $urandom_range(0, MAX_FRAMES - 1));
         else if (roll < 20)
            b = load_beat(CMD_SENSOR, $urandom_range(0, MAX_SENSORS - 1));
         else if (roll < 22) begin
            b = load_beat(CMD_UNUSED, $urandom_range(0, 15));
         end else
            b = factor_beat();
         // The slot field that a load does not use is randomised to keep all bits toggling.
         if (b.cmd == CMD_SENSOR) b.frame = FRAME_W'($urandom_range(0, 15));
         if (b.cmd == CMD_POSE)   b.sensor = SENSOR_W'($urandom_range(0, 7));
         send_beat(b, 1'b0, '{default: '0});
         if (b.cmd != CMD_UNUSED) sent++;
         // Runs of back-to-back beats alternate with gaps.
         if (sent % 60 < 30) idle_sender(pick_gap());
      end
      req_valid   <= 1'b0;
      sender_done = 1'b1;
   end

   // Receiver: random stall, one long hold-off while the sender keeps pushing.
   initial begin
      int gap;
      rsp_stall = 1'b1;
      @(negedge reset);
      // Let the queue and pipeline fill, then block the output for a long stretch.
      repeat (60) @(posedge clock);
      rsp_stall <= 1'b1;
      repeat (150) @(posedge clock);
      forever begin
         if (residuals_seen % 100 < 50) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            gap = pick_gap();
            rsp_stall <= (gap != 0);
            @(posedge clock);
            if (gap > 1) repeat (gap - 1) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   // Checker: samples at the edge, compares against the oldest expectation.
   always @(posedge clock) begin
      residual_type want;
      residual_type hand;
      bit           is_typed;
      if (!reset && rsp_valid && !rsp_stall) begin
         residuals_seen++;
         if (pending_residuals.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected residual beat: res=%0d sq=%0d frame=%0d sensor=%0d",
                        rsp_residual, rsp_residual_squared, rsp_frame_echo,
                        rsp_sensor_echo);
         end else begin
            want     = pending_residuals.pop_front();
            hand     = typed_residuals.pop_front();
            is_typed = typed_flags.pop_front();
            // Hand-typed rows must agree with the predictor too.
            if (is_typed && hand != want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("typed row disagrees with predictor: typed %0d/%0d pred %0d/%0d",
                           hand.res, hand.sq, want.res, want.sq);
            end
            if (rsp_residual !== want.res || rsp_residual_squared !== want.sq ||
                rsp_frame_echo !== want.frame || rsp_sensor_echo !== want.sensor) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("residual mismatch: exp res=%0d sq=%0d f=%0d s=%0d, got res=%0d sq=%0d f=%0d s=%0d",
                           want.res, want.sq, want.frame, want.sensor, rsp_residual,
                           rsp_residual_squared, rsp_frame_echo, rsp_sensor_echo);
            end
         end
      end
   end

   // End of run: drain, allow pipeline latency for stray beats, then report.
   initial begin
      wait (sender_done);
      while (pending_residuals.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Covered %0d table loads and %0d factor evaluations, %0d residuals checked.",
               loads_sent, factors_sent, residuals_seen);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches.", mismatch_count);
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin
      #2000000;
      $display("Timed out.");
      $display("Regression FAIL");
      $finish;
   end

endmodule

// File: files.f
hdl/ptpr_pkg.sv
hdl/ptpr_front.sv
hdl/ptpr_queue.sv
hdl/ptpr_back.sv
hdl/point_to_plane_residual_core.sv
tb/sv/tb.sv
